// ----- rtl/core/mtbd_pkg.sv -----
// shared types, constants and tempering function for the bounded-draw twister
// no dependencies; imported by mtbd_div and mersenne_twister_bounded_draw_top
package mtbd_pkg;

  localparam int WORD_W = 32;
  localparam int VAL_W  = 31;
  localparam int IDX_W  = 10;
  localparam int ADDR_W = 3;
  localparam int TBL_DEPTH = 624;
  localparam int DIV_CNT_W = $clog2(VAL_W);

  localparam logic [IDX_W-1:0] TBL_N    = 10'd624;
  localparam logic [IDX_W-1:0] TBL_M    = 10'd397;
  localparam logic [IDX_W-1:0] IDX_LAST = 10'd623;

  localparam logic [WORD_W-1:0] TW_MATRIX = 32'h9908b0df;
  localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc60000;
  localparam logic [WORD_W-1:0] SEED_RST  = 32'd1;

  localparam logic [ADDR_W-1:0] CFG_ADDR_SEED = 3'd0;

  localparam logic FUNC_RESEED = 1'b0;
  localparam logic FUNC_DRAW   = 1'b1;

  typedef enum logic [12:0] {
    ST_FILL0    = 13'b0000000000001,
    ST_FILL_MUL = 13'b0000000000010,
    ST_FILL_WR  = 13'b0000000000100,
    ST_IDLE     = 13'b0000000001000,
    ST_DRAW     = 13'b0000000010000,
    ST_TEMPER   = 13'b0000000100000,
    ST_CHECK    = 13'b0000001000000,
    ST_DIV      = 13'b0000010000000,
    ST_RESULT   = 13'b0000100000000,
    ST_TW_RD0   = 13'b0001000000000,
    ST_TW_RD1   = 13'b0010000000000,
    ST_TW_A     = 13'b0100000000000,
    ST_TW_B     = 13'b1000000000000
  } mtbd_state_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] rem;
  } div_res_t;

  // standard tempering, then drop the low bit
  function automatic logic [VAL_W-1:0] temper31(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y[WORD_W-1:1];
  endfunction

endpackage

// ----- rtl/core/mersenne_twister_bounded_draw_top.sv -----
// bounded draw from an mt19937 generator; twist table in one 624x32 ram
// depends on mtbd_pkg, mtbd_ram and mtbd_div
// reset: in_stall stays high while the table is seeded from seed
// reseed transaction: the table is filled from seed, then a zero result is offered
// draw transaction: each word is read, tempered and checked, then the serial remainder
//   unit runs (skipped when bound is zero) and the result is offered; a used-up table is
//   twisted first; a rejected word repeats the word loop, one transaction at a time
module mersenne_twister_bounded_draw_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [mtbd_pkg::VAL_W-1:0]    in_bound,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mtbd_pkg::VAL_W-1:0]    out_value,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtbd_pkg::ADDR_W-1:0]   paddr,
  input  logic [mtbd_pkg::WORD_W-1:0]   pwdata,
  output logic [mtbd_pkg::WORD_W-1:0]   prdata,
  output logic                          pready
);
  import mtbd_pkg::*;

  // control state
  mtbd_state_t       state_r, state_nxt;
  logic              fill_item_r, fill_item_nxt;   // fill was caused by a reseed transaction
  logic [IDX_W-1:0]  idx_r, idx_nxt;               // table read index
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;               // fill entry / twist position
  logic [IDX_W-1:0]  far_r, far_nxt;               // twist position plus m, wrapped
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] seed_r, seed_nxt;

  // datapath
  logic [WORD_W-1:0] prev_r, prev_nxt;             // last initializer word
  logic [WORD_W-1:0] prod_r, prod_nxt;             // initializer product
  logic [WORD_W-1:0] cur_r, cur_nxt;               // table[k] before twisting
  logic [WORD_W-1:0] nxtv_r, nxtv_nxt;             // table[k+1]
  logic [VAL_W-1:0]  bound_r, bound_nxt;
  logic [VAL_W-1:0]  v_r, v_nxt;
  logic [VAL_W-1:0]  res_r, res_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;

  // ram side
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // divider side
  logic              div_start;
  div_res_t          div_res;

  // helpers
  logic [WORD_W-1:0] first_word;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] fill_word;
  logic [WORD_W-1:0] tw_y;
  logic [WORD_W-1:0] tw_x;
  logic [IDX_W-1:0]  nxt2;
  logic [IDX_W-1:0]  far_inc;
  logic [VAL_W:0]    reject_sum;
  logic              cfg_wr;
  logic              in_acc;
  logic              out_free;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr == CFG_ADDR_SEED) ? seed_r : '0;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // output register can take a new result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // seed maps to seed*2+1, wrapping
  assign first_word = {seed_r[WORD_W-2:0], 1'b1};
  assign mix        = prev_r ^ (prev_r >> 30);
  assign fill_word  = prod_r + {{(WORD_W-IDX_W){1'b0}}, cnt_r};

  // twist recurrence for entry k
  assign tw_y = {cur_r[WORD_W-1], nxtv_r[WORD_W-2:0]};
  assign tw_x = ram_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? TW_MATRIX : '0);

  assign nxt2    = (cnt_r >= TBL_N - 10'd2) ? cnt_r + 10'd2 - TBL_N : cnt_r + 10'd2;
  assign far_inc = (far_r == IDX_LAST) ? '0 : far_r + 1'b1;

  // a word is rejected when word + bound reaches 2^31
  assign reject_sum = {1'b0, v_r} + {1'b0, bound_r};

  always_comb begin
    state_nxt     = state_r;
    fill_item_nxt = fill_item_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    far_nxt       = far_r;
    seed_nxt      = cfg_wr && (paddr == CFG_ADDR_SEED) ? pwdata : seed_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    nxtv_nxt      = nxtv_r;
    bound_nxt     = bound_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = fill_word;
    ram_raddr     = idx_r;
    div_start     = 1'b0;

    case (state_r)
      // table[0] from the seed
      ST_FILL0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = first_word;
        prev_nxt  = first_word;
        cnt_nxt   = 10'd1;
        state_nxt = ST_FILL_MUL;
      end
      ST_FILL_MUL: begin
        prod_nxt  = INIT_MULT * mix;
        state_nxt = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        ram_we   = 1'b1;
        prev_nxt = fill_word;
        if (cnt_r == IDX_LAST) begin
          idx_nxt = TBL_N;
          if (fill_item_r) begin
            res_nxt   = '0;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_FILL_MUL;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          bound_nxt = in_bound;
          if (in_func == FUNC_RESEED) begin
            fill_item_nxt = 1'b1;
            state_nxt     = ST_FILL0;
          end else begin
            state_nxt = ST_DRAW;
          end
        end
      end
      // fetch the next word, twisting first when the table is used up
      ST_DRAW: begin
        if (idx_r == TBL_N) begin
          state_nxt = ST_TW_RD0;
        end else begin
          ram_raddr = idx_r;
          state_nxt = ST_TEMPER;
        end
      end
      ST_TEMPER: begin
        v_nxt     = temper31(ram_rdata);
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (reject_sum[VAL_W]) begin
          state_nxt = ST_DRAW;
        end else if (bound_r == '0) begin
          res_nxt   = '0;
          state_nxt = ST_RESULT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          res_nxt   = div_res.rem;
          state_nxt = ST_RESULT;
        end
      end
      // wait for room in the output register
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          fill_item_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      // twist: prime table[0] and table[1], then ST_TW_A and ST_TW_B for each entry
      ST_TW_RD0: begin
        ram_raddr = '0;
        cnt_nxt   = '0;
        far_nxt   = TBL_M;
        state_nxt = ST_TW_RD1;
      end
      ST_TW_RD1: begin
        ram_raddr = 10'd1;
        cur_nxt   = ram_rdata;
        state_nxt = ST_TW_A;
      end
      ST_TW_A: begin
        nxtv_nxt  = ram_rdata;
        ram_raddr = far_r;
        state_nxt = ST_TW_B;
      end
      ST_TW_B: begin
        // write k while reading k+2; the addresses never meet
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = tw_x;
        ram_raddr = nxt2;
        cur_nxt   = nxtv_r;
        far_nxt   = far_inc;
        if (cnt_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_DRAW;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_TW_A;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL0;
      fill_item_r <= 1'b0;
      idx_r       <= TBL_N;
      cnt_r       <= '0;
      far_r       <= TBL_M;
      out_valid_r <= 1'b0;
      seed_r      <= SEED_RST;
    end else begin
      state_r     <= state_nxt;
      fill_item_r <= fill_item_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      far_r       <= far_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
    end
    prev_r      <= prev_nxt;
    prod_r      <= prod_nxt;
    cur_r       <= cur_nxt;
    nxtv_r      <= nxtv_nxt;
    bound_r     <= bound_nxt;
    v_r         <= v_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // twist table
  mtbd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // remainder of the accepted word by the bound
  mtbd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(v_r),
    .divisor (bound_r),
    .res     (div_res)
  );

endmodule

// ----- rtl/core/mtbd_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module mtbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mtbd_div.sv -----
// serial restoring remainder unit, one quotient bit per cycle
// depends on mtbd_pkg
module mtbd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mtbd_pkg::VAL_W-1:0]  dividend,
  input  logic [mtbd_pkg::VAL_W-1:0]  divisor,
  output mtbd_pkg::div_res_t          res
);
  import mtbd_pkg::*;

  logic                 active_r, active_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]     rem_r, rem_nxt;
  logic [VAL_W-1:0]     dvd_r, dvd_nxt;
  logic [VAL_W-1:0]     dvs_r, dvs_nxt;
  logic [VAL_W:0]       shifted;
  logic [VAL_W:0]       diff;

  always_comb begin
    shifted    = {rem_r, dvd_r[VAL_W-1]};
    diff       = shifted - {1'b0, dvs_r};
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    dvs_nxt    = dvs_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = DIV_CNT_W'(VAL_W - 1);
      rem_nxt    = '0;
      dvd_nxt    = dividend;
      dvs_nxt    = divisor;
    end else if (active_r) begin
      rem_nxt = diff[VAL_W] ? shifted[VAL_W-1:0] : diff[VAL_W-1:0];
      dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
      if (cnt_r == '0) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res = {done_r, rem_r};

endmodule

// ----- tb/sv/mersenne_twister_bounded_draw_top_tb.sv -----
// self-checking testbench for the bounded-draw mersenne twister block
// depends on mtbd_pkg and mersenne_twister_bounded_draw_top; predicts every draw in-line
module mersenne_twister_bounded_draw_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtbd_pkg::*;

  // twist masks: top bit of one word, low 31 bits of the next
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
  // no transaction for this many cycles ends the run; covers reset seeding,
  // a twist pass, a long rejection run and the long output hold-off
  localparam int unsigned IDLE_LIMIT = 100_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned END_SETTLE = 50;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_func;
  logic [VAL_W-1:0]    in_bound;
  logic                out_valid;
  logic                out_stall;
  logic [VAL_W-1:0]    out_value;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [WORD_W-1:0]   pwdata;
  logic [WORD_W-1:0]   prdata;
  logic                pready;

  // draw predictor state: its own copy of the table, read position and seed
  logic [WORD_W-1:0]   twist_words [TBL_DEPTH];
  int unsigned         word_pos;
  logic [WORD_W-1:0]   seed_shadow;

  // values still owed by the block, oldest first
  logic [VAL_W-1:0]    pending_values [$];

  int unsigned         fail_count;
  int unsigned         send_gap_pct;
  int unsigned         recv_stall_pct;
  bit                  hold_off_req;

  mersenne_twister_bounded_draw_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_bound  (in_bound),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // standard initializer starting from seed*2+1, wrapping at 32 bits
  function automatic void seed_twist_words();
    logic [WORD_W-1:0] prev;
    twist_words[0] = (seed_shadow << 1) + 32'd1;
    for (int i = 1; i < TBL_DEPTH; i++) begin
      prev = twist_words[i-1];
      twist_words[i] = INIT_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
    end
    // next draw regenerates the whole table first
    word_pos = TBL_DEPTH;
  endfunction

  // regenerate all 624 words in place, in index order
  function automatic void twist_pass();
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] x;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      y = (twist_words[k] & UPPER_MASK) | (twist_words[(k + 1) % TBL_DEPTH] & LOWER_MASK);
      x = twist_words[(k + int'(TBL_M)) % TBL_DEPTH] ^ (y >> 1);
      if (y[0]) x = x ^ TW_MATRIX;
      twist_words[k] = x;
    end
    word_pos = 0;
  endfunction

  // next tempered word, low bit dropped
  function automatic logic [VAL_W-1:0] next_draw31();
    logic [WORD_W-1:0] y;
    if (word_pos >= TBL_DEPTH) twist_pass();
    y = twist_words[word_pos];
    word_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y[WORD_W-1:1];
  endfunction

  // value the block must return for one transaction; advances the predictor
  function automatic logic [VAL_W-1:0] expected_value(input logic func,
                                                      input logic [VAL_W-1:0] bound);
    logic [VAL_W-1:0] v;
    if (func == FUNC_RESEED) begin
      seed_twist_words();
      return '0;
    end
    // reject words for which word+bound reaches 2^31
    do
      v = next_draw31();
    while (({1'b0, v} + {1'b0, bound}) >= {1'b0, UPPER_MASK[WORD_W-1:1], 1'b0} );
    if (bound == '0) return '0;
    return v % bound;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one transaction; entered and left at a falling edge, valid left high
  task automatic send_item(input logic func, input logic [VAL_W-1:0] bound);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      in_func  <= 1'($urandom);
      in_bound <= VAL_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_bound <= bound;
    do @(posedge clk); while (in_stall);
    pending_values.push_back(expected_value(func, bound));
    @(negedge clk);
  endtask

  // stop offering and wait until the block has nothing left to return
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  // write the seed register, then read it back
  task automatic cfg_write_seed(input logic [WORD_W-1:0] value);
    logic [WORD_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_SEED;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seed_shadow = value;
    @(negedge clk);
    // read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== value) begin
      $error("seed readback: expected %h, actual %h", value, got);
      fail_count++;
    end
  endtask

  // random bound of random width; the top pattern is trimmed so the
  // rejection loop stays around a few dozen words at worst
  function automatic logic [VAL_W-1:0] random_bound();
    logic [VAL_W-1:0] b;
    int unsigned      w;
    w = $urandom_range(VAL_W, 1);
    b = VAL_W'($urandom) & VAL_W'((64'd1 << w) - 64'd1);
    if (&b[VAL_W-1:VAL_W-5]) b[VAL_W-5] = 1'b0;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // draws straight after reset: table seeded from the reset seed of 1
  task automatic test_power_on_seed();
    send_item(FUNC_DRAW, 31'd1);
    // bound zero: one word consumed, value forced to zero
    send_item(FUNC_DRAW, 31'd0);
    send_item(FUNC_DRAW, 31'd1000);
  endtask

  // bit patterns of the bound and the largest bounds that finish in time
  task automatic test_bound_extremes();
    send_item(FUNC_DRAW, 31'd2);
    send_item(FUNC_DRAW, 31'h2aaa_aaaa);
    send_item(FUNC_DRAW, 31'h5555_5555);
    send_item(FUNC_DRAW, 31'h4000_0000);
    // large bound: about one word in 128 survives the rejection loop
    send_item(FUNC_DRAW, 31'h7f00_0000);
  endtask

  // seed register extremes, seed overflow, and writes that must not reseed
  task automatic test_seed_register();
    drain_pipeline();
    cfg_write_seed(32'h0000_0000);
    send_item(FUNC_RESEED, 31'd0);
    send_item(FUNC_DRAW, 31'd77);
    drain_pipeline();
    // seed*2+1 wraps past 2^32
    cfg_write_seed(32'hffff_ffff);
    // reseed ignores whatever sits in the bound field
    send_item(FUNC_RESEED, 31'h7fff_ffff);
    send_item(FUNC_DRAW, 31'h0001_0000);
    drain_pipeline();
    // wraps to the same first word as seed zero
    cfg_write_seed(32'h8000_0000);
    send_item(FUNC_RESEED, 31'd5);
    send_item(FUNC_DRAW, 31'd77);
    drain_pipeline();
    // a register write alone leaves the table and index alone
    cfg_write_seed(32'd12345);
    send_item(FUNC_DRAW, 31'd999);
    send_item(FUNC_RESEED, 31'd0);
    send_item(FUNC_RESEED, 31'd0);
    send_item(FUNC_DRAW, 31'd999);
  endtask

  // result side held off for a long stretch while transactions keep coming,
  // so the pending result blocks the block and in_stall rises
  task automatic test_output_backpressure();
    drain_pipeline();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b1;
    send_item(FUNC_DRAW, 31'd10);
    send_item(FUNC_DRAW, 31'd1_000_000);
    send_item(FUNC_RESEED, 31'd0);
    send_item(FUNC_DRAW, 31'd3);
    send_item(FUNC_DRAW, 31'h0fff_ffff);
  endtask

  // random mix under one idling setting, started from a fresh random seed
  task automatic test_random_traffic(input int unsigned gap_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned pick;
    drain_pipeline();
    cfg_write_seed($urandom);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    send_item(FUNC_RESEED, VAL_W'($urandom));
    for (int n = 1; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 4)
        send_item(FUNC_RESEED, VAL_W'($urandom));
      else if (pick < 7)
        send_item(FUNC_DRAW, VAL_W'($urandom_range(1, 0)));
      else
        send_item(FUNC_DRAW, random_bound());
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // stall pattern, with one long hold-off counted here on request
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (int n = 1; n < HOLD_OFF_CYCLES; n++) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // compare every accepted result with the oldest pending value
  always @(posedge clk) begin : check_results
    logic [VAL_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        $error("value: no transaction pending, actual %0d", out_value);
        fail_count++;
      end else begin
        want = pending_values.pop_front();
        if (out_value !== want) begin
          $error("value: expected %0d, actual %0d", want, out_value);
          fail_count++;
        end
      end
    end
  end

  // cycles without any transaction on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = FUNC_RESEED;
    in_bound = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = CFG_ADDR_SEED;
    pwdata   = '0;
    fail_count     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    // predictor matches the block's own seeding after reset
    seed_shadow = SEED_RST;
    seed_twist_words();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_power_on_seed();
    test_bound_extremes();
    test_seed_register();
    test_output_backpressure();
    // sender idles more lightly first, then the receiver, then no idling
    test_random_traffic(29, 66, 570);
    test_random_traffic(66, 29, 570);
    test_random_traffic(0, 0, 560);

    drain_pipeline();
    repeat (END_SETTLE) @(negedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
